FILE: src/isl_pkg.sv
// ---------------------------------------------------------------------------
// isl_pkg
// Shared codes, command and state types for the indexed shift list.
// ---------------------------------------------------------------------------
package isl_pkg;

  // fixed port field widths
  localparam int POS_W      = 5;
  localparam int FUNC_W     = 3;
  localparam int IN_WORD_W  = 32;
  localparam int RD_W       = 32;
  localparam int FPOS_W     = 4;
  localparam int CNT_OUT_W  = 5;
  localparam int STAT_W     = 2;

  // request operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_SET    = 3'd2,
    FUNC_GET    = 3'd3,
    FUNC_FIND   = 3'd4,
    FUNC_CLEAR  = 3'd5
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SET,
    CELL_LOAD_FIND,
    CELL_LOAD_GET,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

FILE: src/isl_cell.sv
// ---------------------------------------------------------------------------
// isl_cell
// One list slot: holds an entry, shifts it to or from its neighbors on
// insert and remove, and carries a probe word and flag down the chain.
// ---------------------------------------------------------------------------
module isl_cell #(
  parameter int WORD_BITS = 32,
  parameter int CMP_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  isl_pkg::cell_cmd_t   cmd,
  input  logic [WORD_BITS-1:0] word,
  input  logic [WORD_BITS-1:0] lo_entry,
  input  logic [WORD_BITS-1:0] hi_entry,
  input  logic [WORD_BITS-1:0] hi_probe_word,
  input  logic                 hi_probe_flag,
  output logic [WORD_BITS-1:0] entry,
  output logic [WORD_BITS-1:0] probe_word,
  output logic                 probe_flag
);
  import isl_pkg::*;

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic [WORD_BITS-1:0] entry_r, entry_nxt;
  logic [WORD_BITS-1:0] probe_word_r, probe_word_nxt;
  logic                 probe_flag_r, probe_flag_nxt;
  logic [CMP_W-1:0]     pos_ext;

  assign pos_ext = CMP_W'(cmd.pos);

  // entry update from the broadcast command
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX > pos_ext) begin
          entry_nxt = lo_entry;
        end else if (MY_IDX == pos_ext) begin
          entry_nxt = word;
        end
      end
      CELL_REMOVE: begin
        if (MY_IDX >= pos_ext) begin
          entry_nxt = hi_entry;
        end
      end
      CELL_SET: begin
        if (MY_IDX == pos_ext) begin
          entry_nxt = word;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // probe lane: parallel load, then shift toward cell zero
  always_comb begin
    probe_word_nxt = probe_word_r;
    probe_flag_nxt = probe_flag_r;
    case (cmd.op)
      CELL_LOAD_FIND: begin
        probe_word_nxt = entry_r;
        probe_flag_nxt = (entry_r == word);
      end
      CELL_LOAD_GET: begin
        probe_word_nxt = entry_r;
        probe_flag_nxt = (MY_IDX == pos_ext);
      end
      CELL_SHIFT: begin
        probe_word_nxt = hi_probe_word;
        probe_flag_nxt = hi_probe_flag;
      end
      default: begin
        probe_word_nxt = probe_word_r;
        probe_flag_nxt = probe_flag_r;
      end
    endcase
  end

  // storage, no reset: contents are defined by writes only
  always_ff @(posedge clk) begin
    entry_r      <= entry_nxt;
    probe_word_r <= probe_word_nxt;
    probe_flag_r <= probe_flag_nxt;
  end

  assign entry      = entry_r;
  assign probe_word = probe_word_r;
  assign probe_flag = probe_flag_r;

endmodule

FILE: src/indexed_shift_list_unit.sv
// ---------------------------------------------------------------------------
// indexed_shift_list_unit
// Insert, remove, set, clear and rejected requests give their word in the
//   cycle after acceptance; one such request per cycle while out_ready.
// Get and find run a scan: the probe lane moves one cell per cycle toward
//   cell zero until a flag reaches cell zero or the scan passes the count.
// No new request is taken while a get or find scan is running.
// Reset clears the entry count and control state; entries are not cleared.
// Ordered list of up to DEPTH words kept in a chain of cells with a shared count.
// ---------------------------------------------------------------------------
module indexed_shift_list_unit #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [isl_pkg::FUNC_W-1:0]         in_func,
  input  logic [isl_pkg::POS_W-1:0]          in_position,
  input  logic [isl_pkg::IN_WORD_W-1:0]      in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [isl_pkg::RD_W-1:0]           out_read_word,
  output logic                               out_found,
  output logic [isl_pkg::FPOS_W-1:0]         out_found_position,
  output logic [isl_pkg::CNT_OUT_W-1:0]      out_entry_count,
  output logic [isl_pkg::STAT_W-1:0]         out_status
);
  import isl_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int WX     = (WORD_BITS > IN_WORD_W) ? WORD_BITS : IN_WORD_W;
  localparam int FX     = (IDX_W > FPOS_W) ? IDX_W : FPOS_W;
  localparam int CX     = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic               scan_get_r, scan_get_nxt;
  logic               out_valid_r;

  // result register
  logic [RD_W-1:0]    res_word_r, res_word_nxt;
  logic               res_found_r, res_found_nxt;
  logic [FPOS_W-1:0]  res_fpos_r, res_fpos_nxt;
  logic [CNT_OUT_W-1:0] res_count_r;
  status_t            res_status_r, res_status_nxt;
  logic               res_load;

  // cell row
  cell_cmd_t            cmd;
  logic [WORD_BITS-1:0] ent [DEPTH];
  logic [WORD_BITS-1:0] pw  [DEPTH];
  logic [DEPTH-1:0]     pf;

  // request decode
  func_t              func_in;
  logic               in_accept;
  logic               room;
  logic [CMP_W-1:0]   pos_c, cnt_c;
  logic               pos_ok, pos_ok_ins, full;
  logic               go_scan, scan_hit, scan_miss, scan_done;
  logic [WX-1:0]      word_ext, head_ext;
  logic [WORD_BITS-1:0] word_s;
  logic [FX-1:0]      step_ext;
  logic [CX-1:0]      cnt_ext;
  logic [CNT_W-1:0]   step_next_cnt;

  assign func_in    = func_t'(in_func);
  assign room       = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE) && room;
  assign in_accept  = in_valid && in_ready;

  assign pos_c      = CMP_W'(in_position);
  assign cnt_c      = CMP_W'(count_r);
  assign pos_ok     = pos_c < cnt_c;
  assign pos_ok_ins = pos_c <= cnt_c;
  assign full       = count_r == CNT_W'(DEPTH);

  assign word_ext   = WX'(in_word);
  assign word_s     = word_ext[WORD_BITS-1:0];
  assign head_ext   = WX'(pw[0]);
  assign step_ext   = FX'(step_r);
  assign cnt_ext    = CX'(count_nxt);
  assign step_next_cnt = CNT_W'(step_r) + CNT_W'(1);

  // scan start and finish
  assign go_scan   = in_accept && ((func_in == FUNC_FIND) ||
                                   ((func_in == FUNC_GET) && pos_ok));
  assign scan_hit  = pf[0] && (count_r != '0);
  assign scan_miss = !scan_hit && ((count_r == '0) || (step_next_cnt >= count_r));
  assign scan_done = scan_hit || scan_miss;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    cmd.op         = CELL_HOLD;
    cmd.pos        = in_position;
    count_nxt      = count_r;
    step_nxt       = step_r;
    scan_get_nxt   = scan_get_r;
    res_load       = 1'b0;
    res_word_nxt   = '0;
    res_found_nxt  = 1'b0;
    res_fpos_nxt   = '0;
    res_status_nxt = STATUS_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (func_in)
            FUNC_INSERT: begin
              res_load = 1'b1;
              if (!pos_ok_ins) begin
                res_status_nxt = STATUS_RANGE;
              end else if (full) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                cmd.op    = CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            FUNC_REMOVE: begin
              res_load = 1'b1;
              if (!pos_ok) begin
                res_status_nxt = STATUS_RANGE;
              end else begin
                cmd.op    = CELL_REMOVE;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            FUNC_SET: begin
              res_load = 1'b1;
              if (!pos_ok) begin
                res_status_nxt = STATUS_RANGE;
              end else begin
                cmd.op = CELL_SET;
              end
            end
            FUNC_GET: begin
              if (!pos_ok) begin
                res_load       = 1'b1;
                res_status_nxt = STATUS_RANGE;
              end else begin
                cmd.op       = CELL_LOAD_GET;
                step_nxt     = '0;
                scan_get_nxt = 1'b1;
              end
            end
            FUNC_FIND: begin
              cmd.op       = CELL_LOAD_FIND;
              step_nxt     = '0;
              scan_get_nxt = 1'b0;
            end
            FUNC_CLEAR: begin
              res_load  = 1'b1;
              count_nxt = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          res_load = 1'b1;
          if (scan_get_r) begin
            res_word_nxt = head_ext[RD_W-1:0];
          end else begin
            res_found_nxt = 1'b1;
            res_fpos_nxt  = step_ext[FPOS_W-1:0];
          end
        end else if (scan_miss) begin
          res_load = 1'b1;
        end else begin
          cmd.op   = CELL_SHIFT;
          step_nxt = step_r + IDX_W'(1);
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      scan_get_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      scan_get_r  <= scan_get_nxt;
      out_valid_r <= res_load || (out_valid_r && !out_ready);
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_word_r   <= res_word_nxt;
      res_found_r  <= res_found_nxt;
      res_fpos_r   <= res_fpos_nxt;
      res_count_r  <= cnt_ext[CNT_OUT_W-1:0];
      res_status_r <= res_status_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_word      = res_word_r;
  assign out_found          = res_found_r;
  assign out_found_position = res_fpos_r;
  assign out_entry_count    = res_count_r;
  assign out_status         = res_status_r;

  // row of cells with neighbor links
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] lo_src;
    logic [WORD_BITS-1:0] hi_src;
    logic [WORD_BITS-1:0] hi_pw;
    logic                 hi_pf;

    if (i == 0) begin : g_lo_edge
      assign lo_src = word_s;
    end else begin : g_lo_link
      assign lo_src = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi_edge
      assign hi_src = ent[i];
      assign hi_pw  = '0;
      assign hi_pf  = 1'b0;
    end else begin : g_hi_link
      assign hi_src = ent[i+1];
      assign hi_pw  = pw[i+1];
      assign hi_pf  = pf[i+1];
    end

    isl_cell #(
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W),
      .INDEX     (i)
    ) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .word          (word_s),
      .lo_entry      (lo_src),
      .hi_entry      (hi_src),
      .hi_probe_word (hi_pw),
      .hi_probe_flag (hi_pf),
      .entry         (ent[i]),
      .probe_word    (pw[i]),
      .probe_flag    (pf[i])
    );
  end

endmodule

FILE: verif/isl_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isl_checker
// Watches both channels of the indexed shift list, keeps its own copy of the
// list contents and entry count, predicts one result per accepted request
// and compares every accepted result, field by field, against the oldest one.
// ---------------------------------------------------------------------------
module isl_checker #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [isl_pkg::FUNC_W-1:0]     in_func,
  input  logic [isl_pkg::POS_W-1:0]      in_position,
  input  logic [isl_pkg::IN_WORD_W-1:0]  in_word,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [isl_pkg::RD_W-1:0]       out_read_word,
  input  logic                           out_found,
  input  logic [isl_pkg::FPOS_W-1:0]     out_found_position,
  input  logic [isl_pkg::CNT_OUT_W-1:0]  out_entry_count,
  input  logic [isl_pkg::STAT_W-1:0]     out_status,
  output int                             mismatches,
  output int                             pending
);
  import isl_pkg::*;

  typedef struct packed {
    logic [RD_W-1:0]      read_word;
    logic                 found;
    logic [FPOS_W-1:0]    found_position;
    logic [CNT_OUT_W-1:0] entry_count;
    status_t              status;
  } list_result_t;

  // shadow list contents and length
  logic [IN_WORD_W-1:0] list_words [DEPTH];
  int                   list_len;

  list_result_t         result_q [$];
  int                   errors;

  // apply one request to the shadow list and return the expected result
  function automatic list_result_t apply_request(input logic [FUNC_W-1:0] f,
                                                 input logic [POS_W-1:0] p,
                                                 input logic [IN_WORD_W-1:0] w);
    list_result_t r;
    int           pos;
    r   = '0;
    pos = int'(p);
    case (f)
      FUNC_INSERT: begin
        if (pos > list_len) begin
          r.status = STATUS_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = w;
          list_len++;
        end
      end
      FUNC_REMOVE: begin
        if (pos >= list_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      FUNC_SET: begin
        if (pos >= list_len) r.status = STATUS_RANGE;
        else list_words[pos] = w;
      end
      FUNC_GET: begin
        if (pos >= list_len) r.status = STATUS_RANGE;
        else r.read_word = list_words[pos];
      end
      FUNC_FIND: begin
        // lowest matching position wins
        for (int i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == w) begin
            r.found          = 1'b1;
            r.found_position = i[FPOS_W-1:0];
          end
        end
      end
      FUNC_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = list_len[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
               act_val);
      errors++;
    end
  endtask

  // results first: a result word at this edge always belongs to an earlier request
  always @(posedge clk) begin
    list_result_t exp_res;
    if (!rst_n) begin
      list_len = 0;
      errors   = 0;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual rd=%0h cnt=%0d st=%0d",
                   $time, out_read_word, out_entry_count, out_status);
          errors++;
        end else begin
          exp_res = result_q.pop_front();
          compare_field("read_word", 32'(exp_res.read_word), 32'(out_read_word));
          compare_field("found", 32'(exp_res.found), 32'(out_found));
          compare_field("found_position", 32'(exp_res.found_position),
                        32'(out_found_position));
          compare_field("entry_count", 32'(exp_res.entry_count),
                        32'(out_entry_count));
          compare_field("status", 32'(exp_res.status), 32'(out_status));
        end
      end
      if (in_valid && in_ready)
        result_q.push_back(apply_request(in_func, in_position, in_word));
    end
    mismatches <= errors;
    pending    <= result_q.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Request stimulus for the indexed shift list: a directed pass over empty,
// full and out-of-range cases, then random request streams that grow and
// shrink the list under several sender and receiver idle patterns.
// ---------------------------------------------------------------------------
module tb_top;
  import isl_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam int PHASE_ITEMS = 104;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FUNC_W-1:0]    in_func = '0;
  logic [POS_W-1:0]     in_position = '0;
  logic [IN_WORD_W-1:0] in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [RD_W-1:0]      out_read_word;
  logic                 out_found;
  logic [FPOS_W-1:0]    out_found_position;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic [STAT_W-1:0]    out_status;

  int mismatches;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int len_guess = 0;
  bit growing   = 1'b1;

  logic [IN_WORD_W-1:0] key_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                         32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                         32'h0000_FFFF, 32'hFFFF_0000};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  indexed_shift_list_unit #(.DEPTH(DEPTH), .WORD_BITS(32)) u_top (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_position, .in_word,
    .out_valid, .out_ready, .out_read_word, .out_found, .out_found_position,
    .out_entry_count, .out_status
  );

  isl_checker #(.DEPTH(DEPTH)) u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_func, .in_position, .in_word,
    .out_valid, .out_ready, .out_read_word, .out_found, .out_found_position,
    .out_entry_count, .out_status,
    .mismatches, .pending
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // present one request word and hold it until accepted
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                           input logic [IN_WORD_W-1:0] w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= f;
    in_position <= p;
    in_word     <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // rough length tracking, only to steer positions
    case (f)
      FUNC_INSERT: if (int'(p) <= len_guess && len_guess < DEPTH) len_guess++;
      FUNC_REMOVE: if (int'(p) < len_guess) len_guess--;
      FUNC_CLEAR:  len_guess = 0;
      default: ;
    endcase
  endtask

  function automatic logic [IN_WORD_W-1:0] pick_word();
    if ($urandom_range(99) < 50) return key_pool[3'($urandom_range(7))];
    return $urandom;
  endfunction

  // one random request, mostly well-formed positions
  task automatic send_random();
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    int                roll;
    roll = $urandom_range(99);
    if (growing) begin
      if (roll < 45)      f = FUNC_INSERT;
      else if (roll < 55) f = FUNC_REMOVE;
      else if (roll < 65) f = FUNC_SET;
      else if (roll < 78) f = FUNC_GET;
      else if (roll < 94) f = FUNC_FIND;
      else if (roll < 96) f = FUNC_CLEAR;
      else                f = $urandom_range(1) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
    end else begin
      if (roll < 15)      f = FUNC_INSERT;
      else if (roll < 50) f = FUNC_REMOVE;
      else if (roll < 60) f = FUNC_SET;
      else if (roll < 74) f = FUNC_GET;
      else if (roll < 92) f = FUNC_FIND;
      else if (roll < 95) f = FUNC_CLEAR;
      else                f = $urandom_range(1) ? FUNC_SPARE_LO : FUNC_SPARE_HI;
    end
    if ($urandom_range(99) < 12) begin
      p = POS_W'($urandom_range(31));
    end else if (f == FUNC_INSERT) begin
      roll = $urandom_range(2);
      p = (roll == 0) ? '0 : (roll == 1) ? POS_W'(len_guess) : POS_W'($urandom_range(len_guess));
    end else if (len_guess == 0) begin
      p = POS_W'($urandom_range(DEPTH));
    end else begin
      p = POS_W'($urandom_range(len_guess - 1));
    end
    send_word(f, p, pick_word());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list corners
    send_word(FUNC_GET, 5'd0, 32'h0);
    send_word(FUNC_REMOVE, 5'd0, 32'h0);
    send_word(FUNC_SET, 5'd0, 32'hDEAD_BEEF);
    send_word(FUNC_FIND, 5'd0, 32'h0);
    send_word(FUNC_CLEAR, 5'd0, 32'h0);
    send_word(FUNC_INSERT, 5'd1, 32'h1234_5678);
    // prepend, append, far out of range
    send_word(FUNC_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_word(FUNC_INSERT, 5'd1, 32'h0000_0000);
    send_word(FUNC_INSERT, 5'd31, 32'h1111_1111);
    send_word(FUNC_SET, 5'd1, 32'hA5A5_A5A5);
    send_word(FUNC_GET, 5'd1, 32'h0);
    send_word(FUNC_FIND, 5'd0, 32'hFFFF_FFFF);
    send_word(FUNC_FIND, 5'd0, 32'h1234_5678);
    send_word(FUNC_SPARE_LO, 5'd31, 32'hFFFF_FFFF);
    send_word(FUNC_SPARE_HI, 5'd16, 32'h8000_0001);
    // fill to the top, duplicates included
    while (len_guess < DEPTH) send_word(FUNC_INSERT, POS_W'(len_guess), 32'hA5A5_A5A5);
    send_word(FUNC_INSERT, 5'd16, 32'h2222_2222);
    send_word(FUNC_INSERT, 5'd17, 32'h2222_2222);
    send_word(FUNC_FIND, 5'd0, 32'hA5A5_A5A5);
    send_word(FUNC_GET, 5'd15, 32'h0);
    send_word(FUNC_REMOVE, 5'd15, 32'h0);
    send_word(FUNC_REMOVE, 5'd0, 32'h0);
    send_word(FUNC_CLEAR, 5'd0, 32'h0);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 26 : 0;
      stall_pct = (ph == 2) ? 46 : (ph == 3) ? 26 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 28 == 0) growing = (len_guess < DEPTH / 2) || ($urandom_range(3) == 0);
        send_random();
      end
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: indexed_shift_list_unit.f
src/isl_pkg.sv
src/isl_cell.sv
src/indexed_shift_list_unit.sv
verif/isl_checker.sv
verif/tb_top.sv
